[sv/fcr_pkg.sv]
package fcr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned IN_DATA_W = 3 * WORD_W;
  localparam int unsigned OUT_DATA_W = 9 * WORD_W;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_STIFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_STIFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION = 2'd2;

  localparam logic signed [WORD_W-1:0] INV_SQRT2_Q30 = 32'sd759250125;

  typedef logic signed [67:0] wide_t;

  localparam wide_t Q30_ONE = 68'sd1073741824;
  localparam wide_t WORD_MAX = 68'sd2147483647;
  localparam wide_t WORD_MIN = -68'sd2147483648;

  // Signed value of an unsigned product magnitude
  function automatic wide_t sgn(input logic [63:0] p, input logic neg);
    wide_t v;
    v = $signed({4'b0000, p});
    return neg ? -v : v;
  endfunction

  // Shift right with rounding half away from zero
  function automatic wide_t rsr(input wide_t v, input int unsigned sh);
    logic [67:0] m;
    m = v[67] ? 68'(-v) : 68'(v);
    m = (m + (68'd1 << (sh - 1))) >> sh;
    return v[67] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [67:0] mag_w(input wide_t v);
    return v[67] ? 68'(-v) : 68'(v);
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(input wide_t v);
    logic signed [WORD_W-1:0] r;
    if (v > WORD_MAX) begin
      r = WORD_MAX[WORD_W-1:0];
    end else if (v < WORD_MIN) begin
      r = WORD_MIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/frictional_contact_return_map_top.sv]
// Coulomb penalty contact return map in the local contact frame, signed Q16.16.
// Input stream: tdata holds gap_t1, gap_t2, gap_n (lowest first); tuser is func
// (0 trial update, 1 commit of the trial gap). Output stream: tdata holds
// traction_t1, traction_t2, traction_n, tan_00, tan_01, tan_02, tan_11, tan_12,
// tan_22; tuser holds in_contact then sliding. One result beat per input beat.
// The user must write stiffnesses and the friction coefficient on the cfg port only while
// idle; the block itself does not enforce it. A commit or an out-of-contact trial goes
// straight to the done state. A trial in contact runs through one bit-serial
// shift-and-add multiplier (one multiplier bit per cycle, 8 products when sticking and 19
// when sliding), a bit-serial square root and, for a nonzero shear norm, two
// bit-serial divides of the tangential traction components by that norm.
// One item is worked on at a time; the next beat is accepted as soon as the
// previous result sits in the output register, even while it waits there.
// If the receiver stalls, the finished result is held until the output register
// frees up. Reset clears configuration, gaps, stored traction and the last result.
module frictional_contact_return_map_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // gap_t1, gap_t2, gap_n
  input  logic        s_axis_tuser_i,   // func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [287:0] m_axis_tdata_o,  // traction_t1/t2/n, tan_00/01/02/11/12/22
  output logic [1:0]  m_axis_tuser_o    // in_contact, sliding
);
  import fcr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MLOAD = 3'd1;
  localparam logic [2:0] ST_MRUN  = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [4:0] SP_K0  = 5'd0;
  localparam logic [4:0] SP_K1  = 5'd1;
  localparam logic [4:0] SP_K2  = 5'd2;
  localparam logic [4:0] SP_Q0  = 5'd3;
  localparam logic [4:0] SP_Q1  = 5'd4;
  localparam logic [4:0] SP_Y0  = 5'd5;
  localparam logic [4:0] SP_Y1  = 5'd6;
  localparam logic [4:0] SP_Y2  = 5'd7;
  localparam logic [4:0] SP_MK  = 5'd8;
  localparam logic [4:0] SP_R0  = 5'd9;
  localparam logic [4:0] SP_R1  = 5'd10;
  localparam logic [4:0] SP_SS0 = 5'd11;
  localparam logic [4:0] SP_T0  = 5'd12;
  localparam logic [4:0] SP_SS1 = 5'd13;
  localparam logic [4:0] SP_T1  = 5'd14;
  localparam logic [4:0] SP_SS2 = 5'd15;
  localparam logic [4:0] SP_T2  = 5'd16;
  localparam logic [4:0] SP_M0  = 5'd17;
  localparam logic [4:0] SP_M1  = 5'd18;

  logic [30:0] kn_q, kt_q;
  logic [15:0] mu_q;
  logic signed [WORD_W-1:0] tg_q [3];
  logic signed [WORD_W-1:0] cg_q [3];
  logic signed [WORD_W-1:0] res_q [9];
  logic contact_q, sliding_q;

  logic [2:0] state_q;
  logic [4:0] step_q;

  logic signed [WORD_W-1:0] t_q [3];
  logic signed [WORD_W-1:0] s_q [2];
  logic signed [WORD_W-1:0] x_q;
  logic [WORD_W-1:0] n_q;
  wide_t w_q;
  logic [33:0] mukn_q;

  logic [63:0] a_q, acc_q;
  logic [35:0] b_q;
  logic neg_q;

  logic [63:0] sx_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [62:0] dq_q;
  logic [5:0] cnt_q;
  logic dsel_q;

  logic [287:0] out_data_q;
  logic [1:0] out_user_q;
  logic ov_q;

  logic [39:0] op_a;
  logic [35:0] op_b;
  logic op_neg;
  wide_t d_w [3];
  wide_t pw, pw_r14, pw_r16, pw_r30, yf30, yf16;
  logic [67:0] m_tmp;
  logic [34:0] sq_rn, sq_test;
  logic [31:0] root_d;
  logic [34:0] sq_rem_d;
  logic [32:0] dv_rn;
  logic dv_ge;
  logic [62:0] dq_d;
  logic [31:0] t0_mag, t1_mag;
  logic out_free;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_w[i] = wide_t'(tg_q[i]) - wide_t'(cg_q[i]);
    end
    pw = sgn(acc_q, neg_q);
    pw_r14 = rsr(pw, 14);
    pw_r16 = rsr(pw, 16);
    pw_r30 = rsr(pw, 30);
    yf30 = rsr(w_q, 16) + pw;
    yf16 = rsr(yf30, 14);
    t0_mag = t_q[0][31] ? 32'(-t_q[0]) : 32'(t_q[0]);
    t1_mag = t_q[1][31] ? 32'(-t_q[1]) : 32'(t_q[1]);
  end

  // Operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_neg = 1'b0;
    m_tmp = '0;
    case (step_q)
      SP_K0, SP_K1: begin
        m_tmp = mag_w(d_w[step_q == SP_K0 ? 0 : 1]);
        op_a = {9'b0, kt_q};
        op_b = m_tmp[35:0];
        op_neg = d_w[step_q == SP_K0 ? 0 : 1][67];
      end
      SP_K2: begin
        m_tmp = mag_w(d_w[2]);
        op_a = {9'b0, kn_q};
        op_b = m_tmp[35:0];
        op_neg = d_w[2][67];
      end
      SP_Q0: begin
        op_a = {8'b0, t0_mag};
        op_b = {4'b0, t0_mag};
      end
      SP_Q1: begin
        op_a = {8'b0, t1_mag};
        op_b = {4'b0, t1_mag};
      end
      SP_Y0: begin
        m_tmp = mag_w(wide_t'(s_q[0]));
        op_a = m_tmp[39:0];
        op_b = {4'b0, t0_mag};
        op_neg = s_q[0][31] ^ t_q[0][31];
      end
      SP_Y1: begin
        m_tmp = mag_w(wide_t'(s_q[1]));
        op_a = m_tmp[39:0];
        op_b = {4'b0, t1_mag};
        op_neg = s_q[1][31] ^ t_q[1][31];
      end
      SP_Y2: begin
        m_tmp = mag_w(wide_t'(t_q[2]));
        op_a = {24'b0, mu_q};
        op_b = m_tmp[35:0];
        op_neg = t_q[2][31];
      end
      SP_MK: begin
        op_a = {24'b0, mu_q};
        op_b = {5'b0, kn_q};
      end
      SP_R0, SP_R1: begin
        m_tmp = mag_w(w_q);
        op_a = m_tmp[39:0];
        m_tmp = mag_w(wide_t'(s_q[step_q == SP_R0 ? 0 : 1]));
        op_b = m_tmp[35:0];
        op_neg = w_q[67] ^ s_q[step_q == SP_R0 ? 0 : 1][31];
      end
      SP_SS0, SP_SS1, SP_SS2: begin
        m_tmp = mag_w(wide_t'(s_q[step_q == SP_SS2 ? 1 : 0]));
        op_a = m_tmp[39:0];
        m_tmp = mag_w(wide_t'(s_q[step_q == SP_SS0 ? 0 : 1]));
        op_b = m_tmp[35:0];
        op_neg = s_q[step_q == SP_SS2 ? 1 : 0][31] ^ s_q[step_q == SP_SS0 ? 0 : 1][31];
      end
      SP_T0, SP_T1, SP_T2: begin
        m_tmp = mag_w(wide_t'(x_q));
        op_a = {9'b0, kt_q};
        op_b = m_tmp[35:0];
        op_neg = x_q[31];
      end
      SP_M0, SP_M1: begin
        m_tmp = mag_w(wide_t'(s_q[step_q == SP_M0 ? 0 : 1]));
        op_a = {6'b0, mukn_q};
        op_b = m_tmp[35:0];
        op_neg = s_q[step_q == SP_M0 ? 0 : 1][31];
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // Square root: two radicand bits per cycle; divide: one dividend bit per cycle
  always_comb begin
    sq_rn = {rem_q[32:0], sx_q[63:62]};
    sq_test = {1'b0, root_q, 2'b01};
    if (sq_rn >= sq_test) begin
      sq_rem_d = sq_rn - sq_test;
      root_d = {root_q[30:0], 1'b1};
    end else begin
      sq_rem_d = sq_rn;
      root_d = {root_q[30:0], 1'b0};
    end
    dv_rn = {rem_q[31:0], dq_q[62]};
    dv_ge = dv_rn >= {1'b0, n_q};
    dq_d = {dq_q[61:0], dv_ge};
  end

  assign out_free = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o = out_data_q;
  assign m_axis_tuser_o = out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kn_q <= '0;
      kt_q <= '0;
      mu_q <= '0;
      for (int i = 0; i < 3; i++) begin
        tg_q[i] <= '0;
        cg_q[i] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        res_q[i] <= '0;
      end
      contact_q <= 1'b0;
      sliding_q <= 1'b0;
      state_q <= ST_IDLE;
      step_q <= SP_K0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NORMAL_STIFF: kn_q <= cfg_data_i;
          CFG_SHEAR_STIFF:  kt_q <= cfg_data_i;
          CFG_FRICTION:     mu_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (ov_q && m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            if (s_axis_tuser_i) begin
              for (int i = 0; i < 3; i++) begin
                cg_q[i] <= tg_q[i];
              end
              state_q <= ST_DONE;
            end else begin
              tg_q[0] <= $signed(s_axis_tdata_i[31:0]);
              tg_q[1] <= $signed(s_axis_tdata_i[63:32]);
              tg_q[2] <= $signed(s_axis_tdata_i[95:64]);
              sliding_q <= 1'b0;
              if ($signed(s_axis_tdata_i[95:64]) > 0) begin
                for (int i = 0; i < 9; i++) begin
                  res_q[i] <= '0;
                end
                contact_q <= 1'b0;
                state_q <= ST_DONE;
              end else begin
                contact_q <= 1'b1;
                step_q <= SP_K0;
                state_q <= ST_MLOAD;
              end
            end
          end
        end
        ST_MLOAD: begin
          a_q <= {24'b0, op_a};
          b_q <= op_b;
          neg_q <= op_neg;
          acc_q <= '0;
          state_q <= ST_MRUN;
        end
        ST_MRUN: begin
          if (b_q != '0) begin
            if (b_q[0]) begin
              acc_q <= acc_q + a_q;
            end
            a_q <= {a_q[62:0], 1'b0};
            b_q <= {1'b0, b_q[35:1]};
          end else begin
            state_q <= ST_MLOAD;
            step_q <= step_q + 5'd1;
            case (step_q)
              SP_K0: t_q[0] <= sat32(wide_t'(res_q[0]) + pw_r16);
              SP_K1: t_q[1] <= sat32(wide_t'(res_q[1]) + pw_r16);
              SP_K2: t_q[2] <= sat32(wide_t'(res_q[2]) + pw_r16);
              SP_Q0: w_q <= pw;
              SP_Q1: begin
                sx_q <= w_q[63:0] + acc_q;
                rem_q <= '0;
                root_q <= '0;
                cnt_q <= 6'd31;
                state_q <= ST_SQRT;
              end
              SP_Y0: w_q <= pw;
              SP_Y1: w_q <= w_q + pw;
              SP_Y2: begin
                if (yf30 > 0) begin
                  w_q <= yf16;
                  sliding_q <= 1'b1;
                end else begin
                  // stick: keep the prediction, diagonal tangent
                  res_q[0] <= t_q[0];
                  res_q[1] <= t_q[1];
                  res_q[2] <= t_q[2];
                  res_q[3] <= $signed({1'b0, kt_q});
                  res_q[4] <= '0;
                  res_q[5] <= '0;
                  res_q[6] <= $signed({1'b0, kt_q});
                  res_q[7] <= '0;
                  res_q[8] <= $signed({1'b0, kn_q});
                  state_q <= ST_DONE;
                end
              end
              SP_MK: mukn_q <= pw_r14[33:0];
              SP_R0: res_q[0] <= sat32(wide_t'(t_q[0]) - pw_r30);
              SP_R1: res_q[1] <= sat32(wide_t'(t_q[1]) - pw_r30);
              SP_SS0, SP_SS2: x_q <= $signed(32'(Q30_ONE - pw_r30));
              SP_SS1: x_q <= pw_r30[31:0];
              SP_T0: res_q[3] <= sat32(pw_r30);
              SP_T1: res_q[4] <= sat32(-pw_r30);
              SP_T2: res_q[6] <= sat32(pw_r30);
              SP_M0: res_q[5] <= sat32(-pw_r30);
              SP_M1: begin
                res_q[7] <= sat32(-pw_r30);
                res_q[2] <= t_q[2];
                res_q[8] <= $signed({1'b0, kn_q});
                state_q <= ST_DONE;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_SQRT: begin
          rem_q <= sq_rem_d;
          root_q <= root_d;
          sx_q <= {sx_q[61:0], 2'b00};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            n_q <= root_d;
            if (root_d == '0) begin
              s_q[0] <= INV_SQRT2_Q30;
              s_q[1] <= INV_SQRT2_Q30;
              step_q <= SP_Y0;
              state_q <= ST_MLOAD;
            end else begin
              dq_q <= ({31'b0, t0_mag} << 30) + {32'b0, root_d[31:1]};
              rem_q <= '0;
              cnt_q <= 6'd62;
              dsel_q <= 1'b0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q <= {2'b00, dv_ge ? dv_rn - {1'b0, n_q} : dv_rn};
          dq_q <= dq_d;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            if (t_q[dsel_q][31]) begin
              s_q[dsel_q] <= -$signed({1'b0, dq_d[30:0]});
            end else begin
              s_q[dsel_q] <= $signed({1'b0, dq_d[30:0]});
            end
            if (!dsel_q) begin
              dq_q <= ({31'b0, t1_mag} << 30) + {32'b0, n_q[31:1]};
              rem_q <= '0;
              cnt_q <= 6'd62;
              dsel_q <= 1'b1;
            end else begin
              step_q <= SP_Y0;
              state_q <= ST_MLOAD;
            end
          end
        end
        ST_DONE: begin
          // hold the result until the output register frees up
          if (out_free) begin
            ov_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= {res_q[8], res_q[7], res_q[6], res_q[5], res_q[4],
                     res_q[3], res_q[2], res_q[1], res_q[0]};
      out_user_q <= {sliding_q, contact_q};
    end
  end

  a_slide_needs_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_user_q[1] |-> out_user_q[0])
    else $error("sliding result without contact");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> n_q != '0)
    else $error("direction divide with zero shear norm");

  a_free_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_user_q[0] |-> out_data_q == '0)
    else $error("out-of-contact result carries nonzero data");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> ov_q && state_q == ST_IDLE)
    else $error("finished result not moved to output register");

endmodule

[verif/tb_frictional_contact_return_map_top.sv]
module tb_frictional_contact_return_map_top;
  import fcr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic FUNC_TRIAL = 1'b0;
  localparam logic FUNC_COMMIT = 1'b1;
  localparam longint W_HI = 64'sd2147483647;
  localparam longint W_LO = -64'sd2147483648;
  localparam longint Q30_UNIT = 64'sd1073741824;
  localparam longint DIAG_Q30 = 64'sd759250125;

  typedef struct packed {
    logic [287:0] data;
    logic [1:0]   user;
  } contact_res_t;

  typedef struct {
    logic        func;
    logic [31:0] g1;
    logic [31:0] g2;
    logic [31:0] gn;
    bit          zero_exp;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [30:0]  cfg_data_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [95:0]  s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [287:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  frictional_contact_return_map_top DUT (.*);

  // Predictor state
  longint kn_r, kt_r, mu_r;
  longint stored_t[3], commit_g[3], trial_g[3];
  contact_res_t last_res;
  contact_res_t pending_q[$];
  int mismatches = 0;
  int stall_left = 0;
  bit quiet;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 8000000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bit [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint mul_round(longint a, longint b, int sh);
    bit [63:0] p, m;
    p = mag64(a) * mag64(b);
    m = (p + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint shr_round(longint v, int sh);
    bit [63:0] m;
    m = (mag64(v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_word(longint v);
    return v > W_HI ? W_HI : (v < W_LO ? W_LO : v);
  endfunction

  function automatic bit [63:0] root_floor(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_dir(longint t, bit [63:0] n);
    bit [63:0] q;
    q = ((mag64(t) << 30) + (n >> 1)) / n;
    return t < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Return map for one beat; updates the contact history
  task automatic return_map(input logic func, input logic [95:0] gap, output contact_res_t r);
    longint g[3], t[3], res[9];
    longint s0, s1, yf, yf16, mukn;
    bit [63:0] n;
    bit in_c, slide;
    if (func == FUNC_COMMIT) begin
      for (int i = 0; i < 3; i++) commit_g[i] = trial_g[i];
      r = last_res;
      return;
    end
    in_c = 0;
    slide = 0;
    for (int i = 0; i < 3; i++) begin
      g[i] = longint'($signed(gap[32*i +: 32]));
      trial_g[i] = g[i];
    end
    for (int i = 0; i < 9; i++) res[i] = 0;
    if (g[2] <= 0) begin
      in_c = 1;
      for (int i = 0; i < 3; i++)
        t[i] = clamp_word(stored_t[i] + mul_round(i < 2 ? kt_r : kn_r, g[i] - commit_g[i], 16));
      n = root_floor(64'(t[0] * t[0]) + 64'(t[1] * t[1]));
      if (n == 0) begin
        s0 = DIAG_Q30;
        s1 = DIAG_Q30;
      end else begin
        s0 = unit_dir(t[0], n);
        s1 = unit_dir(t[1], n);
      end
      yf = shr_round(s0 * t[0] + s1 * t[1], 16) + mu_r * t[2];
      if (yf > 0) begin
        slide = 1;
        yf16 = shr_round(yf, 14);
        mukn = shr_round(mu_r * kn_r, 14);
        res[0] = clamp_word(t[0] - mul_round(yf16, s0, 30));
        res[1] = clamp_word(t[1] - mul_round(yf16, s1, 30));
        res[2] = t[2];
        res[3] = clamp_word(mul_round(kt_r, Q30_UNIT - shr_round(s0 * s0, 30), 30));
        res[4] = clamp_word(-mul_round(kt_r, shr_round(s0 * s1, 30), 30));
        res[5] = clamp_word(-mul_round(mukn, s0, 30));
        res[6] = clamp_word(mul_round(kt_r, Q30_UNIT - shr_round(s1 * s1, 30), 30));
        res[7] = clamp_word(-mul_round(mukn, s1, 30));
        res[8] = clamp_word(kn_r);
      end else begin
        res[0] = t[0];
        res[1] = t[1];
        res[2] = t[2];
        res[3] = clamp_word(kt_r);
        res[6] = clamp_word(kt_r);
        res[8] = clamp_word(kn_r);
      end
    end
    for (int i = 0; i < 3; i++) stored_t[i] = res[i];
    for (int i = 0; i < 9; i++) last_res.data[32*i +: 32] = res[i][31:0];
    last_res.user = {slide, in_c};
    r = last_res;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_NORMAL_STIFF: kn_r = longint'(val);
      CFG_SHEAR_STIFF:  kt_r = longint'(val);
      CFG_FRICTION:     mu_r = longint'(val[15:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_stiffness(input logic [30:0] kn, input logic [30:0] kt,
                               input logic [30:0] mu);
    write_reg(CFG_NORMAL_STIFF, kn);
    write_reg(CFG_SHEAR_STIFF, kt);
    write_reg(CFG_FRICTION, mu);
  endtask

  // Drive one beat; zero_exp replaces the prediction with an all-zero result
  task automatic send_beat(input logic func, input logic [95:0] gap, input bit zero_exp);
    int gap_len, r;
    contact_res_t exp_r;
    r = $urandom_range(0, 9);
    gap_len = quiet ? 0 : (r < 6 ? 0 : (r < 9 ? $urandom_range(1, 3) : $urandom_range(10, 60)));
    if (gap_len > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap_len) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = gap;
    s_axis_tuser_i = func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    return_map(func, gap, exp_r);
    pending_q.push_back(zero_exp ? contact_res_t'(0) : exp_r);
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!quiet && $urandom_range(0, 15) == 0)
        stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    end
  end

  always @(posedge clk_i) begin
    contact_res_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata_o);
      end else begin
        want = pending_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (m_axis_tdata_o[32*i +: 32] !== want.data[32*i +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h got %h", i, want.data[32*i +: 32],
                       m_axis_tdata_o[32*i +: 32]);
          end
        end
        if (m_axis_tuser_o !== want.user) begin
          mismatches++;
          if (mismatches <= 10)
            $display("contact/sliding: expected %b got %b", want.user, m_axis_tuser_o);
        end
      end
    end
  end

  dir_row_t dir_rows[16] = '{
    '{FUNC_COMMIT, 32'h0, 32'h0, 32'h0, 1},
    '{FUNC_TRIAL, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 1},
    '{FUNC_TRIAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1},
    '{FUNC_TRIAL, 32'h0, 32'h0, 32'h0, 0},
    '{FUNC_TRIAL, 32'h0, 32'h0, 32'hFFFF_0000, 0},
    '{FUNC_TRIAL, 32'h0004_0000, 32'h0, 32'hFFFF_8000, 0},
    '{FUNC_TRIAL, 32'h0000_1000, 32'hFFFF_F000, 32'hFFF0_0000, 0},
    '{FUNC_COMMIT, 32'h0, 32'h0, 32'h0, 0},
    '{FUNC_TRIAL, 32'h0000_2000, 32'hFFFF_E000, 32'hFFE0_0000, 0},
    '{FUNC_TRIAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0},
    '{FUNC_TRIAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0},
    '{FUNC_COMMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0},
    '{FUNC_TRIAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0},
    '{FUNC_TRIAL, 32'h0, 32'h0003_0000, 32'hFFFF_FFFF, 0},
    '{FUNC_TRIAL, 32'h0, 32'h0, 32'h0000_0002, 0},
    '{FUNC_COMMIT, 32'h0, 32'h0, 32'h0, 0}
  };

  initial begin
    logic [31:0] g[3];
    logic fn;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    quiet = 0;
    kn_r = 0;
    kt_r = 0;
    mu_r = 0;
    last_res = '0;
    for (int i = 0; i < 3; i++) begin
      stored_t[i] = 0;
      commit_g[i] = 0;
      trial_g[i] = 0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_stiffness(31'h0010_0000, 31'h0008_0000, 31'd8192);
    write_reg(CFG_SPARE, 31'h7FFF_FFFF);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].func, {dir_rows[i].gn, dir_rows[i].g2, dir_rows[i].g1},
                dir_rows[i].zero_exp);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_stiffness(31'h0000_0000, 31'h0000_0000, 31'd0);
        1: set_stiffness(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'hFFFF);
        2: set_stiffness(31'h0020_0000, 31'h0010_0000, 31'd4096);
        3: set_stiffness(31'h0001_0000, 31'h0040_0000, 31'd16384);
        default: set_stiffness(31'($urandom_range(0, 32'h00FF_FFFF)),
                               31'($urandom_range(0, 32'h00FF_FFFF)),
                               31'($urandom_range(0, 65535)));
      endcase
      quiet = (ph == 3);
      repeat (200) begin
        fn = ($urandom_range(0, 4) == 0) ? FUNC_COMMIT : FUNC_TRIAL;
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(0, 3) == 0) g[i] = $urandom();
          else g[i] = 32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
        end
        // keep most trials in contact
        if ($urandom_range(0, 4) != 0 && !g[2][31]) g[2] = -g[2];
        send_beat(fn, {g[2], g[1], g[0]}, 0);
      end
      drain();
    end

    quiet = 1;
    repeat (50) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
